// ----- src/multi_stack_engine_core_macros.svh -----
// Assertion helpers for the stack engine.
`ifndef MULTI_STACK_ENGINE_CORE_MACROS_SVH
`define MULTI_STACK_ENGINE_CORE_MACROS_SVH

// same-cycle implication
`define MSE_ASSERT_IMP(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("same-cycle check failed");

// next-cycle implication
`define MSE_ASSERT_NXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("next-cycle check failed");

`endif

// ----- src/mse_pkg.sv -----
package mse_pkg;

    localparam int NUM_STACKS_DEF  = 8;
    localparam int STACK_DEPTH_DEF = 16;
    localparam int DATA_WIDTH_DEF  = 32;

    localparam int OP_W     = 2;
    localparam int SEL_W    = 3;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int STK_REG_W = 4;
    localparam int DEP_REG_W = 5;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
    localparam logic [OP_W-1:0] OP_POP    = 2'd1;
    localparam logic [OP_W-1:0] OP_LIST   = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd3;

    localparam logic REG_STACKS = 1'b0;
    localparam logic REG_DEPTH  = 1'b1;

    typedef enum logic [1:0] {
        K_PUSH,
        K_POP,
        K_LIST,
        K_INVALID
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [SEL_W-1:0]   sel;
        logic [VAL_W-1:0]   value;
    } t_cmd;

endpackage

// ----- src/mse_ram.sv -----
module mse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/mse_front.sv -----
module mse_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [mse_pkg::OP_W-1:0]           i_op,
    input  logic [mse_pkg::SEL_W-1:0]          i_stack_select,
    input  logic [mse_pkg::VAL_W-1:0]          i_value,
    input  logic [mse_pkg::STK_REG_W-1:0]      i_stacks_in_use,
    input  logic                               i_pop,
    output logic                               o_busy,
    output logic                               o_cmd_valid,
    output mse_pkg::t_cmd                      o_cmd
);

    mse_pkg::t_cmd r_q [0:1];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;

    mse_pkg::t_cmd w_cmd;
    logic          w_acc;
    logic          w_push;

    always_comb begin
        w_cmd.sel   = i_stack_select;
        w_cmd.value = i_value;
        if ({1'b0, i_stack_select} >= i_stacks_in_use) begin
            w_cmd.kind = mse_pkg::K_INVALID;
        end else begin
            case (i_op)
                mse_pkg::OP_PUSH: w_cmd.kind = mse_pkg::K_PUSH;
                mse_pkg::OP_POP:  w_cmd.kind = mse_pkg::K_POP;
                default:          w_cmd.kind = mse_pkg::K_LIST;
            endcase
        end
    end

    assign o_busy      = (r_cnt == 2'd2);
    assign w_acc       = i_start && !o_busy;
    assign w_push      = w_acc && (i_op != mse_pkg::OP_UNUSED);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_pop};
        end
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

endmodule

// ----- src/mse_back.sv -----
module mse_back #(
    parameter int NUM_STACKS  = mse_pkg::NUM_STACKS_DEF,
    parameter int STACK_DEPTH = mse_pkg::STACK_DEPTH_DEF,
    parameter int DATA_WIDTH  = mse_pkg::DATA_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cmd_valid,
    input  mse_pkg::t_cmd                      i_cmd,
    output logic                               o_cmd_pop,
    input  logic [mse_pkg::DEP_REG_W-1:0]      i_depth_in_use,
    input  logic                               i_clear,
    output logic                               o_valid,
    output logic [mse_pkg::VAL_W-1:0]          o_data,
    output logic [mse_pkg::STATUS_W-1:0]       o_status,
    output logic                               o_last
);

    localparam int SU = (NUM_STACKS < 8) ? NUM_STACKS : 8;
    localparam int SW = (SU > 1) ? $clog2(SU) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int MD = SU * STACK_DEPTH;
    localparam int AW = (MD > 1) ? $clog2(MD) : 1;
    localparam logic [DATA_WIDTH-1:0] DMASK = '1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP_RD,
        S_LIST
    } t_state;

    t_state                          r_state, n_state;
    logic [AW-1:0]                   r_base, n_base;
    logic [CW-1:0]                   r_idx, n_idx;
    logic [CW-1:0]                   r_cnt, n_cnt;
    logic [CW-1:0]                   r_fill [0:SU-1];
    logic [CW-1:0]                   n_fill [0:SU-1];
    logic                            r_valid, n_valid;
    logic [mse_pkg::VAL_W-1:0]       r_data, n_data;
    logic [mse_pkg::STATUS_W-1:0]    r_status, n_status;
    logic                            r_last, n_last;

    logic [SW-1:0]                   w_sidx;
    logic [CW-1:0]                   w_n;
    logic [AW-1:0]                   w_base;
    logic                            w_we;
    logic [AW-1:0]                   w_waddr;
    logic [DATA_WIDTH-1:0]           w_wdata;
    logic                            w_re;
    logic [AW-1:0]                   w_raddr;
    logic [DATA_WIDTH-1:0]           w_rdata;
    logic                            w_list_last;

    assign w_sidx      = i_cmd.sel[SW-1:0];
    assign w_n         = r_fill[w_sidx];
    assign w_base      = AW'(int'(w_sidx) * STACK_DEPTH);
    assign w_waddr     = w_base + AW'(w_n);
    assign w_wdata     = DATA_WIDTH'($unsigned(i_cmd.value));
    assign w_list_last = (CW'(r_idx + 1'b1) == r_cnt);

    always_comb begin
        n_state  = r_state;
        n_base   = r_base;
        n_idx    = r_idx;
        n_cnt    = r_cnt;
        n_fill   = r_fill;
        n_valid  = 1'b0;
        n_data   = r_data;
        n_status = r_status;
        n_last   = r_last;
        o_cmd_pop = 1'b0;
        w_we     = 1'b0;
        w_re     = 1'b0;
        w_raddr  = r_base + AW'(r_idx) + AW'(1);
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_base    = w_base;
                    n_valid   = 1'b1;
                    n_data    = '0;
                    n_status  = mse_pkg::ST_OK;
                    n_last    = 1'b1;
                    case (i_cmd.kind)
                        mse_pkg::K_PUSH: begin
                            if (32'(w_n) >= 32'(i_depth_in_use)) begin
                                n_status = mse_pkg::ST_FULL;
                            end else begin
                                w_we           = 1'b1;
                                n_fill[w_sidx] = w_n + 1'b1;
                            end
                        end
                        mse_pkg::K_POP: begin
                            if (w_n == '0) begin
                                n_data   = 32'(DMASK);
                                n_status = mse_pkg::ST_EMPTY;
                            end else begin
                                n_valid        = 1'b0;
                                n_fill[w_sidx] = w_n - 1'b1;
                                w_re           = 1'b1;
                                w_raddr        = w_base + AW'(w_n - 1'b1);
                                n_state        = S_POP_RD;
                            end
                        end
                        mse_pkg::K_LIST: begin
                            if (w_n == '0) begin
                                n_status = mse_pkg::ST_EMPTY;
                            end else begin
                                n_valid = 1'b0;
                                n_cnt   = w_n;
                                n_idx   = '0;
                                w_re    = 1'b1;
                                w_raddr = w_base;
                                n_state = S_LIST;
                            end
                        end
                        default: begin
                            n_status = mse_pkg::ST_INVALID;
                        end
                    endcase
                end
            end
            S_POP_RD: begin
                n_valid  = 1'b1;
                n_data   = 32'(w_rdata);
                n_status = mse_pkg::ST_OK;
                n_last   = 1'b1;
                n_state  = S_IDLE;
            end
            S_LIST: begin
                n_valid  = 1'b1;
                n_data   = 32'(w_rdata);
                n_status = mse_pkg::ST_OK;
                n_last   = w_list_last;
                if (w_list_last) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                    w_re  = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (i_clear) begin
            for (int i = 0; i < SU; i++) begin
                n_fill[i] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            for (int i = 0; i < SU; i++) begin
                r_fill[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_fill  <= n_fill;
        end
        r_base   <= n_base;
        r_idx    <= n_idx;
        r_cnt    <= n_cnt;
        r_data   <= n_data;
        r_status <= n_status;
        r_last   <= n_last;
    end

    mse_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (MD)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_valid  = r_valid;
    assign o_data   = r_data;
    assign o_status = r_status;
    assign o_last   = r_last;

endmodule

// ----- src/multi_stack_engine_core.sv -----
// Several LIFO stacks sharing one element RAM, each stack with its own
// region and fill count.
// Request channel: a beat is taken when start is high and busy is low;
// i_op selects push, pop or list on stack i_stack_select. Op code 3 is
// taken and dropped. busy rises when the two-entry command queue is full.
// Result channel: each beat shows for one cycle with o_result_valid;
// o_last marks the final beat of a request. The receiver cannot stall.
// Result path: push, invalid stack and empty cases answer through the command
// queue and the result register; a pop also passes the RAM read register;
// a list of n entries, after the same path, gives one beat per cycle.
// The back end takes the next command only in its idle state; a pop or a
// non-empty list keeps it busy while the registered RAM read port returns data.
// Config: APB, register 0 stacks in use at 0x0, register 1 depth at 0x4.
// Any write empties all stacks; write only when no request is in flight.
// Reset empties all stacks and loads stacks 8, depth 16; no clearing pass.
`include "multi_stack_engine_core_macros.svh"

module multi_stack_engine_core #(
    parameter int NUM_STACKS  = mse_pkg::NUM_STACKS_DEF,
    parameter int STACK_DEPTH = mse_pkg::STACK_DEPTH_DEF,
    parameter int DATA_WIDTH  = mse_pkg::DATA_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [mse_pkg::OP_W-1:0]           i_op,
    input  logic [mse_pkg::SEL_W-1:0]          i_stack_select,
    input  logic signed [mse_pkg::VAL_W-1:0]   i_value,
    output logic                               o_result_valid,
    output logic signed [mse_pkg::VAL_W-1:0]   o_data,
    output logic [mse_pkg::STATUS_W-1:0]       o_status,
    output logic                               o_last,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [mse_pkg::PADDR_W-1:0]        paddr,
    input  logic [mse_pkg::PDATA_W-1:0]        pwdata,
    output logic [mse_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready
);

    localparam int STK_RST = (NUM_STACKS < 8) ? NUM_STACKS : 8;
    localparam int DEP_RST = (STACK_DEPTH < 16) ? STACK_DEPTH : 16;

    logic [mse_pkg::STK_REG_W-1:0] r_stacks, n_stacks;
    logic [mse_pkg::DEP_REG_W-1:0] r_depth, n_depth;
    logic [mse_pkg::STK_REG_W-1:0] w_stk_v;
    logic [mse_pkg::DEP_REG_W-1:0] w_dep_v;
    logic                          w_wr;

    logic                          w_cmd_valid;
    logic                          w_cmd_pop;
    mse_pkg::t_cmd                 w_cmd;
    logic [mse_pkg::VAL_W-1:0]     w_data;
    logic                          w_res_err;
    logic                          w_req_take;

    assign pready  = 1'b1;
    assign w_wr    = psel && penable && pwrite && pready;
    assign w_stk_v = pwdata[mse_pkg::STK_REG_W-1:0];
    assign w_dep_v = pwdata[mse_pkg::DEP_REG_W-1:0];

    always_comb begin
        n_stacks = r_stacks;
        n_depth  = r_depth;
        if (w_wr) begin
            case (paddr[2])
                mse_pkg::REG_STACKS: begin
                    if (w_stk_v == '0) begin
                        n_stacks = mse_pkg::STK_REG_W'(1);
                    end else if (int'(w_stk_v) > NUM_STACKS) begin
                        n_stacks = mse_pkg::STK_REG_W'(NUM_STACKS);
                    end else begin
                        n_stacks = w_stk_v;
                    end
                end
                default: begin
                    if (w_dep_v == '0) begin
                        n_depth = mse_pkg::DEP_REG_W'(1);
                    end else if (int'(w_dep_v) > STACK_DEPTH) begin
                        n_depth = mse_pkg::DEP_REG_W'(STACK_DEPTH);
                    end else begin
                        n_depth = w_dep_v;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stacks <= mse_pkg::STK_REG_W'(STK_RST);
            r_depth  <= mse_pkg::DEP_REG_W'(DEP_RST);
        end else begin
            r_stacks <= n_stacks;
            r_depth  <= n_depth;
        end
    end

    always_comb begin
        case (paddr[2])
            mse_pkg::REG_STACKS: prdata = mse_pkg::PDATA_W'(r_stacks);
            default:             prdata = mse_pkg::PDATA_W'(r_depth);
        endcase
    end

    mse_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_op            (i_op),
        .i_stack_select  (i_stack_select),
        .i_value         (i_value),
        .i_stacks_in_use (r_stacks),
        .i_pop           (w_cmd_pop),
        .o_busy          (busy),
        .o_cmd_valid     (w_cmd_valid),
        .o_cmd           (w_cmd)
    );

    mse_back #(
        .NUM_STACKS  (NUM_STACKS),
        .STACK_DEPTH (STACK_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (w_cmd_valid),
        .i_cmd          (w_cmd),
        .o_cmd_pop      (w_cmd_pop),
        .i_depth_in_use (r_depth),
        .i_clear        (w_wr),
        .o_valid        (o_result_valid),
        .o_data         (w_data),
        .o_status       (o_status),
        .o_last         (o_last)
    );

    assign o_data = w_data;

    assign w_res_err  = o_result_valid && (o_status != mse_pkg::ST_OK);
    assign w_req_take = start && !busy && (i_op != mse_pkg::OP_UNUSED);

    `MSE_ASSERT_IMP(a_err_is_last, i_clk, i_rst_n, w_res_err, o_last)
    `MSE_ASSERT_IMP(a_pop_has_cmd, i_clk, i_rst_n, w_cmd_pop, w_cmd_valid)
    `MSE_ASSERT_NXT(a_take_queues, i_clk, i_rst_n, w_req_take, w_cmd_valid)

endmodule

// ----- tb/sv/multi_stack_engine_core_tb.sv -----
module multi_stack_engine_core_tb;

    localparam int NS = mse_pkg::NUM_STACKS_DEF;
    localparam int SD = mse_pkg::STACK_DEPTH_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 30;
    localparam logic [mse_pkg::PADDR_W-1:0] ADDR_STACKS = 3'd0;
    localparam logic [mse_pkg::PADDR_W-1:0] ADDR_DEPTH  = 3'd4;

    typedef struct packed {
        logic [mse_pkg::OP_W-1:0]  op;
        logic [mse_pkg::SEL_W-1:0] sel;
        logic [mse_pkg::VAL_W-1:0] value;
    } t_request;

    typedef struct packed {
        logic [mse_pkg::VAL_W-1:0]    data;
        logic [mse_pkg::STATUS_W-1:0] status;
        logic                         last;
    } t_beat;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                start = 1'b0;
    logic                                busy;
    logic [mse_pkg::OP_W-1:0]            i_op = '0;
    logic [mse_pkg::SEL_W-1:0]           i_stack_select = '0;
    logic signed [mse_pkg::VAL_W-1:0]    i_value = '0;
    logic                                o_result_valid;
    logic signed [mse_pkg::VAL_W-1:0]    o_data;
    logic [mse_pkg::STATUS_W-1:0]        o_status;
    logic                                o_last;
    logic                                psel = 1'b0;
    logic                                penable = 1'b0;
    logic                                pwrite = 1'b0;
    logic [mse_pkg::PADDR_W-1:0]         paddr = '0;
    logic [mse_pkg::PDATA_W-1:0]         pwdata = '0;
    logic [mse_pkg::PDATA_W-1:0]         prdata;
    logic                                pready;

    t_request    pending_requests[$];
    t_beat       expected_beats[$];
    t_request    next_req;
    t_beat       want;
    logic        req_beat = 1'b0;
    int unsigned idle_pct = 0;
    int unsigned error_count = 0;
    int unsigned quiet_cycles = 0;

    // shadow of the engine state
    logic [mse_pkg::VAL_W-1:0] stack_mem [0:NS*SD-1];
    int unsigned               fill_level [NS];
    int unsigned               stacks_cfg;
    int unsigned               depth_cfg;

    multi_stack_engine_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_stack_select (i_stack_select),
        .i_value        (i_value),
        .o_result_valid (o_result_valid),
        .o_data         (o_data),
        .o_status       (o_status),
        .o_last         (o_last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #5 i_clk = ~i_clk;

    function automatic void push_beat(logic [mse_pkg::VAL_W-1:0] data,
                                      logic [mse_pkg::STATUS_W-1:0] status,
                                      logic last);
        t_beat b;
        b.data = data;
        b.status = status;
        b.last = last;
        expected_beats.push_back(b);
    endfunction

    function automatic void predict_request(logic [mse_pkg::OP_W-1:0] op,
                                            logic [mse_pkg::SEL_W-1:0] sel,
                                            logic [mse_pkg::VAL_W-1:0] value);
        int unsigned base;
        int unsigned n;
        if (op == mse_pkg::OP_UNUSED) return;
        if (sel >= stacks_cfg) begin
            push_beat('0, mse_pkg::ST_INVALID, 1'b1);
            return;
        end
        base = sel * SD;
        n = fill_level[sel];
        case (op)
            mse_pkg::OP_PUSH: begin
                if (n >= depth_cfg) begin
                    push_beat('0, mse_pkg::ST_FULL, 1'b1);
                end else begin
                    stack_mem[base + n] = value;
                    fill_level[sel] = n + 1;
                    push_beat('0, mse_pkg::ST_OK, 1'b1);
                end
            end
            mse_pkg::OP_POP: begin
                if (n == 0) begin
                    push_beat('1, mse_pkg::ST_EMPTY, 1'b1);
                end else begin
                    fill_level[sel] = n - 1;
                    push_beat(stack_mem[base + n - 1], mse_pkg::ST_OK, 1'b1);
                end
            end
            default: begin
                if (n == 0) push_beat('0, mse_pkg::ST_EMPTY, 1'b1);
                for (int unsigned i = 0; i < n; i++)
                    push_beat(stack_mem[base + i], mse_pkg::ST_OK, i + 1 == n);
            end
        endcase
    endfunction

    function automatic int unsigned saturate(int unsigned v, int unsigned limit);
        if (v == 0) return 1;
        if (v > limit) return limit;
        return v;
    endfunction

    function automatic void add_request(logic [mse_pkg::OP_W-1:0] op,
                                        logic [mse_pkg::SEL_W-1:0] sel,
                                        logic [mse_pkg::VAL_W-1:0] value);
        t_request r;
        r.op = op;
        r.sel = sel;
        r.value = value;
        pending_requests.push_back(r);
    endfunction

    // bursts of pushes, an optional list, then pops; some noise in between
    task automatic queue_random(int unsigned count);
        int unsigned made;
        logic [mse_pkg::SEL_W-1:0] sel;
        int unsigned pushes;
        int unsigned pops;
        logic [mse_pkg::OP_W-1:0] op;
        made = 0;
        while (made < count) begin
            if ($urandom_range(9) == 0) begin
                op = mse_pkg::OP_W'($urandom_range(3));
                add_request(op, mse_pkg::SEL_W'($urandom_range(NS - 1)), $urandom);
                if (op != mse_pkg::OP_UNUSED) made++;
            end else begin
                sel = mse_pkg::SEL_W'(($urandom_range(7) == 0) ? $urandom_range(NS - 1)
                                                    : $urandom_range(stacks_cfg - 1));
                pushes = $urandom_range(depth_cfg + 1, 1);
                for (int unsigned i = 0; i < pushes; i++)
                    add_request(mse_pkg::OP_PUSH, sel, $urandom);
                made += pushes;
                if ($urandom_range(1)) begin
                    add_request(mse_pkg::OP_LIST, sel, $urandom);
                    made++;
                end
                pops = $urandom_range(pushes + 1, 0);
                for (int unsigned i = 0; i < pops; i++)
                    add_request(mse_pkg::OP_POP, sel, $urandom);
                made += pops;
            end
        end
    endtask

    task automatic wait_drained();
        bit done;
        done = 0;
        while (!done) begin
            @(posedge i_clk);
            if (pending_requests.size() == 0 && !start) begin
                @(negedge i_clk);
                done = (expected_beats.size() == 0);
            end
        end
    endtask

    task automatic apb_write(logic [mse_pkg::PADDR_W-1:0] addr,
                             logic [mse_pkg::PDATA_W-1:0] data);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic reconfigure(int unsigned stacks, int unsigned depth);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        apb_write(ADDR_STACKS, stacks);
        stacks_cfg = saturate(stacks, NS);
        foreach (fill_level[i]) fill_level[i] = 0;
        apb_write(ADDR_DEPTH, depth);
        depth_cfg = saturate(depth, SD);
        foreach (fill_level[i]) fill_level[i] = 0;
        @(posedge i_clk);
    endtask

    // request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || req_beat) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= idle_pct) begin
                next_req = pending_requests.pop_front();
                start <= 1'b1;
                i_op <= next_req.op;
                i_stack_select <= next_req.sel;
                i_value <= next_req.value;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // result monitor, prediction on each request beat, watchdog
    always @(posedge i_clk) begin
        req_beat <= start && !busy;
        if (i_rst_n) begin
            if (o_result_valid) begin
                if (expected_beats.size() == 0) begin
                    $error("unexpected result beat: data %h status %0d last %0b",
                           o_data, o_status, o_last);
                    error_count++;
                end else begin
                    want = expected_beats.pop_front();
                    if (o_data !== want.data) begin
                        $error("data mismatch: expected %h, actual %h", want.data, o_data);
                        error_count++;
                    end
                    if (o_status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, o_status);
                        error_count++;
                    end
                    if (o_last !== want.last) begin
                        $error("last mismatch: expected %0b, actual %0b", want.last, o_last);
                        error_count++;
                    end
                end
            end
            if (start && !busy) predict_request(i_op, i_stack_select, i_value);
            if ((start && !busy) || o_result_valid || (psel && penable && pready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        stacks_cfg = NS;
        depth_cfg = SD;
        foreach (fill_level[i]) fill_level[i] = 0;
        foreach (stack_mem[i]) stack_mem[i] = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default configuration: value extremes, drain to empty, unused op
        idle_pct = 6;
        add_request(mse_pkg::OP_PUSH, 3'd0, 32'h8000_0000);
        add_request(mse_pkg::OP_PUSH, 3'd0, 32'h7FFF_FFFF);
        add_request(mse_pkg::OP_PUSH, 3'd0, 32'h0000_0000);
        add_request(mse_pkg::OP_PUSH, 3'd0, 32'hFFFF_FFFF);
        add_request(mse_pkg::OP_LIST, 3'd0, 32'h0);
        repeat (5) add_request(mse_pkg::OP_POP, 3'd0, 32'h0);
        add_request(mse_pkg::OP_LIST, 3'd0, 32'h0);
        add_request(mse_pkg::OP_UNUSED, 3'd7, 32'hAAAA_AAAA);
        add_request(mse_pkg::OP_PUSH, 3'd7, 32'h5555_5555);
        add_request(mse_pkg::OP_LIST, 3'd7, 32'h0);
        add_request(mse_pkg::OP_POP, 3'd7, 32'h0);
        queue_random(70);

        // small stacks: full push and invalid selectors
        reconfigure(3, 4);
        add_request(mse_pkg::OP_PUSH, 3'd2, 32'h1111_1111);
        add_request(mse_pkg::OP_PUSH, 3'd2, 32'h2222_2222);
        add_request(mse_pkg::OP_PUSH, 3'd2, 32'h3333_3333);
        add_request(mse_pkg::OP_PUSH, 3'd2, 32'h4444_4444);
        add_request(mse_pkg::OP_PUSH, 3'd2, 32'h5555_5555);
        add_request(mse_pkg::OP_LIST, 3'd2, 32'h0);
        add_request(mse_pkg::OP_PUSH, 3'd3, 32'h6666_6666);
        add_request(mse_pkg::OP_POP, 3'd7, 32'h0);
        add_request(mse_pkg::OP_LIST, 3'd4, 32'h0);
        add_request(mse_pkg::OP_POP, 3'd2, 32'h0);
        queue_random(55);

        idle_pct = 58;
        reconfigure(0, 0);
        queue_random(35);
        reconfigure(15, 31);
        queue_random(50);

        idle_pct = 0;
        reconfigure(6, 16);
        queue_random(50);
        reconfigure(8, 1);
        queue_random(25);

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+src
src/mse_pkg.sv
src/mse_ram.sv
src/mse_front.sv
src/mse_back.sv
src/multi_stack_engine_core.sv
tb/sv/multi_stack_engine_core_tb.sv
